### sv/quaternion_to_euler_angles_macros.svh
// Assertion macros for the quaternion to Euler angles checker.
// Uses clk and rst_n of the module that expands them.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define Q2E_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2e assertion failed");

// Next-cycle implication, disabled during reset.
`define Q2E_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2e assertion failed");

`endif

### sv/q2e_pkg.sv
// Shared types, widths and the CORDIC angle table for the quaternion to Euler block.
// No dependencies.
`timescale 1ns / 1ps

package q2e_pkg;

  localparam int Q2E_SAMPLE_WIDTH  = 16;
  localparam int Q2E_CORDIC_STAGES = 16;

  localparam int Q2E_WORK_FRAC  = 30;  // working scale: 1.0 = 2^30
  localparam int Q2E_XW         = 37;  // CORDIC vector width
  localparam int Q2E_ZW         = 34;  // CORDIC angle width
  localparam int Q2E_RW         = 62;  // square root remainder / root width
  localparam int Q2E_SQRT_CELLS = Q2E_WORK_FRAC + 1;
  localparam int Q2E_ATAN_DEPTH = 32;

  localparam logic signed [Q2E_ZW-1:0] Q2E_PI_WORK = 34'sd3373259426;
  localparam int Q2E_ANGLE_LIMIT      = 25736;
  localparam int Q2E_HALF_ANGLE_LIMIT = 12868;

  // atan(2^-i) in radians * 2^30, rounded
  localparam logic signed [Q2E_ZW-1:0] Q2E_ATAN [Q2E_ATAN_DEPTH] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic signed [Q2E_XW-1:0] x;
    logic signed [Q2E_XW-1:0] y;
    logic signed [Q2E_ZW-1:0] z;
    logic                     zero;  // null vector, angle forced to 0
  } q2e_lane_t;

  typedef struct packed {
    logic [Q2E_RW-1:0]        n;
    logic [Q2E_RW-1:0]        res;
    q2e_lane_t                roll;
    q2e_lane_t                yaw;
    logic signed [Q2E_XW-1:0] s;
    logic                     clamped;
  } q2e_sq_t;

  typedef struct packed {
    q2e_lane_t roll;
    q2e_lane_t yaw;
    q2e_lane_t pitch;
    logic      clamped;
  } q2e_cd_t;

endpackage

### sv/quaternion_to_euler_angles.sv
// Quaternion to Z-Y-X Euler angles, fully pipelined.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell.
//
// Usage:
//  - Input channel: in_valid/in_stall with the four quaternion parts in
//    signed Q1.(SAMPLE_WIDTH-1). A transfer happens when in_valid is high
//    and in_stall is low.
//  - Output channel: out_valid/out_stall with roll and yaw (Q3.13,
//    +-25736), pitch (Q2.13, +-12868) and pitch_clamped.
//  - Pipeline registers in order: multiply, sum/scale, square,
//    31 square root cells, CORDIC_STAGES CORDIC cells, output rounding.
//  - Throughput is one sample per cycle while no result is held; every cell passes
//    its data on to the next cell whenever the pipeline advances, so samples follow back to back.
//  - When the receiver stalls a waiting result, the whole pipeline
//    freezes and in_stall rises in the same cycle; nothing is dropped.
//  - Synchronous reset clears all valid flags; no data state is kept.
`timescale 1ns / 1ps

module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = Q2E_SAMPLE_WIDTH,
  parameter int CORDIC_STAGES = Q2E_CORDIC_STAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_w,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_roll_angle,
  output logic signed [14:0]             out_pitch_angle,
  output logic signed [15:0]             out_yaw_angle,
  output logic                           out_pitch_clamped
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int PW  = 2 * W;                  // exact product
  localparam int TW  = 2 * W + 3;              // sum terms
  localparam int SH  = (W >= 32) ? 2 : 0;      // pre-shift at widest input
  localparam int E   = 2 * W - 2 - SH;         // product fraction bits
  localparam int SHR = (E >= Q2E_WORK_FRAC) ? E - Q2E_WORK_FRAC : 0;
  localparam int SHL = (E <  Q2E_WORK_FRAC) ? Q2E_WORK_FRAC - E : 0;
  localparam int EXW = (2 * W + 4 > 40) ? 2 * W + 4 : 40;
  localparam int NP  = 9;
  localparam int QW  = Q2E_ZW - 17;            // rounded angle width

  localparam logic signed [TW-1:0] ONE = TW'(1) <<< E;

  // product slots
  localparam int P_WX = 0, P_YZ = 1, P_XX = 2, P_YY = 3;
  localparam int P_WY = 4, P_ZX = 5, P_WZ = 6, P_XY = 7;
  localparam int P_ZZ = 8;

  // Global advance: freeze everything while a result is held.
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage A: exact products ----------------
  logic                 a_valid_r;
  logic signed [PW-1:0] p_r [NP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[P_WX] <= PW'(in_quat_w) * PW'(in_quat_x);
      p_r[P_YZ] <= PW'(in_quat_y) * PW'(in_quat_z);
      p_r[P_XX] <= PW'(in_quat_x) * PW'(in_quat_x);
      p_r[P_YY] <= PW'(in_quat_y) * PW'(in_quat_y);
      p_r[P_WY] <= PW'(in_quat_w) * PW'(in_quat_y);
      p_r[P_ZX] <= PW'(in_quat_z) * PW'(in_quat_x);
      p_r[P_WZ] <= PW'(in_quat_w) * PW'(in_quat_z);
      p_r[P_XY] <= PW'(in_quat_x) * PW'(in_quat_y);
      p_r[P_ZZ] <= PW'(in_quat_z) * PW'(in_quat_z);
    end
  end

  // ---------------- stage B: terms, clamp, scale, pre-rotation ----------------
  function automatic logic signed [TW-1:0] pt(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p >>> SH;
    return TW'(q);
  endfunction

  function automatic logic signed [Q2E_XW-1:0] to_work(input logic signed [TW-1:0] t);
    logic signed [EXW-1:0] v;
    v = EXW'(t);
    v = (v >>> SHR) <<< SHL;
    return $signed(v[Q2E_XW-1:0]);
  endfunction

  // turn left-half-plane vectors by pi, flag the null vector
  function automatic q2e_lane_t prerot(input logic signed [Q2E_XW-1:0] y,
                                       input logic signed [Q2E_XW-1:0] x);
    q2e_lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (x[Q2E_XW-1]) begin
      l.z = y[Q2E_XW-1] ? -Q2E_PI_WORK : Q2E_PI_WORK;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  logic signed [TW-1:0] t0, t1, t2, t3, t4, t2c;
  logic                 clamp_nxt;

  always_comb begin
    t0 = (pt(p_r[P_WX]) + pt(p_r[P_YZ])) <<< 1;
    t1 = ONE - ((pt(p_r[P_XX]) + pt(p_r[P_YY])) <<< 1);
    t2 = (pt(p_r[P_WY]) - pt(p_r[P_ZX])) <<< 1;
    t3 = (pt(p_r[P_WZ]) + pt(p_r[P_XY])) <<< 1;
    t4 = ONE - ((pt(p_r[P_YY]) + pt(p_r[P_ZZ])) <<< 1);
    priority if (t2 > ONE) begin
      t2c       = ONE;
      clamp_nxt = 1'b1;
    end else if (t2 < -ONE) begin
      t2c       = -ONE;
      clamp_nxt = 1'b1;
    end else begin
      t2c       = t2;
      clamp_nxt = 1'b0;
    end
  end

  logic                     b_valid_r;
  q2e_lane_t                b_roll_r, b_yaw_r;
  logic signed [Q2E_XW-1:0] b_s_r;
  logic                     b_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_roll_r  <= prerot(to_work(t0), to_work(t1));
      b_yaw_r   <= prerot(to_work(t3), to_work(t4));
      b_s_r     <= to_work(t2c);
      b_clamp_r <= clamp_nxt;
    end
  end

  // ---------------- stage C: 1 - s^2 ----------------
  logic signed [63:0] sq_prod;
  q2e_sq_t            c_nxt, c_r;
  logic               c_valid_r;

  assign sq_prod = 64'($signed(b_s_r[31:0])) * 64'($signed(b_s_r[31:0]));

  always_comb begin
    c_nxt.n       = (Q2E_RW'(1) << (2 * Q2E_WORK_FRAC)) - sq_prod[Q2E_RW-1:0];
    c_nxt.res     = '0;
    c_nxt.roll    = b_roll_r;
    c_nxt.yaw     = b_yaw_r;
    c_nxt.s       = b_s_r;
    c_nxt.clamped = b_clamp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  // ---------------- square root chain ----------------
  logic    sq_valid [Q2E_SQRT_CELLS+1];
  q2e_sq_t sq_data  [Q2E_SQRT_CELLS+1];

  assign sq_valid[0] = c_valid_r;
  assign sq_data[0]  = c_r;

  for (genvar j = 0; j < Q2E_SQRT_CELLS; j++) begin : g_sqrt
    q2e_sqrt_cell #(.K(Q2E_SQRT_CELLS - 1 - j)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (sq_valid[j]),
      .data_in   (sq_data[j]),
      .valid_out (sq_valid[j+1]),
      .data_out  (sq_data[j+1])
    );
  end

  // ---------------- CORDIC chain ----------------
  logic    cd_valid [CORDIC_STAGES+1];
  q2e_cd_t cd_data  [CORDIC_STAGES+1];

  always_comb begin
    cd_valid[0]              = sq_valid[Q2E_SQRT_CELLS];
    cd_data[0].roll          = sq_data[Q2E_SQRT_CELLS].roll;
    cd_data[0].yaw           = sq_data[Q2E_SQRT_CELLS].yaw;
    cd_data[0].pitch.x       = $signed(Q2E_XW'(sq_data[Q2E_SQRT_CELLS].res[Q2E_WORK_FRAC:0]));
    cd_data[0].pitch.y       = sq_data[Q2E_SQRT_CELLS].s;
    cd_data[0].pitch.z       = '0;
    cd_data[0].pitch.zero    = 1'b0;
    cd_data[0].clamped       = sq_data[Q2E_SQRT_CELLS].clamped;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(.I(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (cd_valid[i]),
      .data_in   (cd_data[i]),
      .valid_out (cd_valid[i+1]),
      .data_out  (cd_data[i+1])
    );
  end

  // ---------------- output: round to Q3.13 and saturate ----------------
  function automatic logic signed [QW-1:0] to_q13(input q2e_lane_t l, input int lim);
    logic signed [Q2E_ZW-1:0] zr;
    logic signed [QW-1:0]     r, hi;
    zr = l.z + (Q2E_ZW'(1) <<< 16);
    r  = QW'(zr >>> 17);
    hi = QW'(lim);
    if (l.zero) begin
      r = '0;
    end else if (r > hi) begin
      r = hi;
    end else if (r < -hi) begin
      r = -hi;
    end
    return r;
  endfunction

  logic signed [QW-1:0] roll_q, pitch_q, yaw_q;
  logic signed [15:0]   roll_r, yaw_r;
  logic signed [14:0]   pitch_r;
  logic                 clamp_r;

  assign roll_q  = to_q13(cd_data[CORDIC_STAGES].roll, Q2E_ANGLE_LIMIT);
  assign yaw_q   = to_q13(cd_data[CORDIC_STAGES].yaw, Q2E_ANGLE_LIMIT);
  assign pitch_q = to_q13(cd_data[CORDIC_STAGES].pitch, Q2E_HALF_ANGLE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cd_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= roll_q[15:0];
      yaw_r   <= yaw_q[15:0];
      pitch_r <= pitch_q[14:0];
      clamp_r <= cd_data[CORDIC_STAGES].clamped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_roll_angle    = roll_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = clamp_r;

endmodule

### sv/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root; carries the angle lanes along.
// Depends on q2e_pkg.
`timescale 1ns / 1ps

module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int K = 0  // this cell tests bit 2^(2K)
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    valid_in,
  input  q2e_sq_t data_in,
  output logic    valid_out,
  output q2e_sq_t data_out
);

  localparam logic [Q2E_RW-1:0] BIT = Q2E_RW'(1) << (2 * K);

  logic    valid_r;
  q2e_sq_t data_r, data_nxt;
  logic [Q2E_RW-1:0] trial;

  always_comb begin
    trial    = data_in.res + BIT;
    data_nxt = data_in;
    if (data_in.n >= trial) begin
      data_nxt.n   = data_in.n - trial;
      data_nxt.res = (data_in.res >> 1) + BIT;
    end else begin
      data_nxt.res = data_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

### sv/q2e_cordic_cell.sv
// One vectoring CORDIC iteration for the roll, yaw and pitch lanes.
// Depends on q2e_pkg.
`timescale 1ns / 1ps

module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int I = 0  // iteration index, shift by I
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    valid_in,
  input  q2e_cd_t data_in,
  output logic    valid_out,
  output q2e_cd_t data_out
);

  localparam logic signed [Q2E_ZW-1:0] ANG = Q2E_ATAN[I];

  function automatic q2e_lane_t rot(input q2e_lane_t l);
    q2e_lane_t o;
    o = l;
    if (!l.y[Q2E_XW-1]) begin
      o.x = l.x + (l.y >>> I);
      o.y = l.y - (l.x >>> I);
      o.z = l.z + ANG;
    end else begin
      o.x = l.x - (l.y >>> I);
      o.y = l.y + (l.x >>> I);
      o.z = l.z - ANG;
    end
    return o;
  endfunction

  logic    valid_r;
  q2e_cd_t data_r, data_nxt;

  always_comb begin
    data_nxt       = data_in;
    data_nxt.roll  = rot(data_in.roll);
    data_nxt.yaw   = rot(data_in.yaw);
    data_nxt.pitch = rot(data_in.pitch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

### sv/q2e_checker.sv
// Port-level checks for quaternion_to_euler_angles, bound to the top level.
// Depends on quaternion_to_euler_angles_macros.svh.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_macros.svh"

module q2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_roll_angle,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_yaw_angle
);

  logic [46:0] angles;
  logic        in_range;

  assign angles   = {out_roll_angle, out_yaw_angle, out_pitch_angle};
  assign in_range = (out_pitch_angle <= 15'sd12868) && (out_pitch_angle >= -15'sd12868) &&
                    (out_roll_angle <= 16'sd25736) && (out_roll_angle >= -16'sd25736) &&
                    (out_yaw_angle <= 16'sd25736) && (out_yaw_angle >= -16'sd25736);

  // held result stays offered
  `Q2E_ASSERT_NXT(a_hold_valid, out_valid && out_stall, out_valid)
  // held result keeps its angles
  `Q2E_ASSERT_NXT(a_hold_data, out_valid && out_stall, $stable(angles))
  // input backpressure only while a result is held
  `Q2E_ASSERT_IMP(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))
  // angles within their saturation ranges
  `Q2E_ASSERT_IMP(a_range, out_valid, in_range)

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_roll_angle  (out_roll_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_yaw_angle   (out_yaw_angle)
);
